/* design/head_tail_marker_trim_macros.svh */
// assertion macros for the head/tail marker trim block
// expects clk and arst_n in the scope of the module that uses them
`ifndef HEAD_TAIL_MARKER_TRIM_MACROS_SVH
`define HEAD_TAIL_MARKER_TRIM_MACROS_SVH

// same-cycle implication, disabled during reset
`define HTMT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define HTMT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/htmt_pkg.sv */
// shared types and constants for the head/tail marker trim block
// no dependencies
package htmt_pkg;

	localparam int MARKER_MAX_DEF = 8;
	localparam int PAT_W          = 64;
	localparam int LEN_W          = 4;
	localparam int CFG_IDX_W      = 2;

	// result kinds
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_DISCARD = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_PAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL_PAT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL_LEN = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// per-cycle command to the window chain
	typedef struct packed {
		logic shift;
		logic load;
	} chain_ctrl_t;

	// summary of the window chain
	typedef struct packed {
		logic       hit_all;
		logic [7:0] head;
	} chain_stat_t;

endpackage

/* design/head_tail_marker_trim.sv */
// top level of the head/tail marker trim block: control, config and output sequencer
// depends on htmt_pkg, htmt_chain and head_tail_marker_trim_macros.svh
//
// channel  | signals                          | request
// ---------+----------------------------------+-------------------------------
// input    | in_valid, in_ready, in_data      | one stream byte, end flag
// output   | out_valid, out_ready, out_data   | one result: byte/discard/end
// config   | cfg_we, cfg_index, cfg_wdata     | one register write, no wait
//
// one input request per cycle while the output register is free or being taken
// a final byte with window bytes left is followed by a flush of those bytes, then the end result
// the flush walks the cell row one byte per cycle while the output slot is free, in_ready low meanwhile
// reset: registers zero, empty window, tail mode on (head length is zero)
// a stalled output holds in_ready low until the result is taken
`include "head_tail_marker_trim_macros.svh"

module head_tail_marker_trim import htmt_pkg::*; #(
	parameter int MARKER_MAX = MARKER_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_wdata
);

	localparam int CNT_W = $clog2(MARKER_MAX + 1);
	localparam int IDX_W = (MARKER_MAX > 1) ? $clog2(MARKER_MAX) : 1;

	typedef enum logic [1:0] {S_RUN, S_FLUSH, S_END} seq_state_t;

	logic [PAT_W-1:0] head_pat_q, tail_pat_q;
	logic [LEN_W-1:0] head_len_q, tail_len_q;
	logic [CNT_W-1:0] cnt_q;
	logic             mode_q;
	logic             fin_q;

	seq_state_t       state_q;
	logic [CNT_W-1:0] fcnt_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [LEN_W-1:0] len_raw;
	logic [CNT_W-1:0] len, cnt_eff, cnt_after, wpos;
	logic [PAT_W-1:0] pat;
	logic [IDX_W-1:0] last_idx;
	logic [7:0]       last_pat, b, oldest;
	logic             full, match, accept, go, slot_free;
	logic             fin_after, mode_after, pending;
	logic             r1_valid;
	logic [1:0]       r1_kind;
	logic [7:0]       r1_byte;
	chain_ctrl_t      ctrl;
	chain_stat_t      stat;

	assign b         = in_data.in_byte;
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_RUN) && slot_free;
	assign accept    = in_valid && in_ready;

	// active marker, length saturated to the window size
	assign len_raw  = mode_q ? tail_len_q : head_len_q;
	assign len      = (len_raw > LEN_W'(MARKER_MAX)) ? CNT_W'(MARKER_MAX) : CNT_W'(len_raw);
	assign pat      = mode_q ? tail_pat_q : head_pat_q;
	assign last_idx = IDX_W'(len - CNT_W'(1));
	assign last_pat = pat[8*last_idx +: 8];

	assign cnt_eff = (cnt_q >= len) ? '0 : cnt_q;
	assign full    = (len != '0) && (cnt_eff == len - CNT_W'(1));
	assign match   = full && stat.hit_all && (b == last_pat);
	assign oldest  = (cnt_eff == '0) ? b : stat.head;
	assign go      = accept && !fin_q && (len != '0);

	// first result of a request and the state it leaves
	always_comb begin
		r1_valid   = 1'b0;
		r1_kind    = KIND_BYTE;
		r1_byte    = 8'h00;
		fin_after  = fin_q;
		mode_after = mode_q;
		cnt_after  = cnt_q;
		if (!fin_q) begin
			if (len == '0) begin
				r1_valid = 1'b1;
				r1_byte  = b;
			end else if (full) begin
				r1_valid = 1'b1;
				if (match) begin
					cnt_after = '0;
					if (mode_q) begin
						r1_kind   = KIND_END;
						fin_after = 1'b1;
					end else begin
						r1_kind    = KIND_DISCARD;
						mode_after = 1'b1;
					end
				end else begin
					r1_byte   = oldest;
					cnt_after = len - CNT_W'(1);
				end
			end else begin
				cnt_after = cnt_eff + CNT_W'(1);
			end
		end
	end

	assign pending = in_data.end_of_stream && !fin_after;

	// window chain commands
	always_comb begin
		ctrl.shift = 1'b0;
		ctrl.load  = 1'b0;
		wpos       = cnt_eff;
		if (state_q == S_FLUSH && slot_free) begin
			ctrl.shift = 1'b1;
		end else if (go && !match) begin
			ctrl.load = 1'b1;
			if (full) begin
				// drop the oldest byte and append at the new end
				ctrl.shift = 1'b1;
				wpos       = cnt_eff - CNT_W'(1);
			end
		end
	end

	htmt_chain #(
		.MARKER_MAX (MARKER_MAX)
	) u_chain (
		.clk      (clk),
		.ctrl     (ctrl),
		.wpos     (wpos),
		.live_cnt (cnt_eff),
		.din      (b),
		.pat      (pat),
		.stat     (stat)
	);

	// config registers and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_pat_q <= '0;
			head_len_q <= '0;
			tail_pat_q <= '0;
			tail_len_q <= '0;
			cnt_q      <= '0;
			mode_q     <= 1'b1;
			fin_q      <= 1'b0;
		end else if (cfg_we) begin
			cnt_q  <= '0;
			fin_q  <= 1'b0;
			// tail mode follows the head length as it stands after the write
			mode_q <= (cfg_index == CFG_HEAD_LEN) ? (cfg_wdata[LEN_W-1:0] == '0)
				: (head_len_q == '0);
			case (cfg_index)
				CFG_HEAD_PAT: head_pat_q <= cfg_wdata;
				CFG_HEAD_LEN: head_len_q <= cfg_wdata[LEN_W-1:0];
				CFG_TAIL_PAT: tail_pat_q <= cfg_wdata;
				CFG_TAIL_LEN: tail_len_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end else if (accept) begin
			if (in_data.end_of_stream) begin
				cnt_q  <= '0;
				fin_q  <= 1'b0;
				mode_q <= (head_len_q == '0);
			end else begin
				cnt_q  <= cnt_after;
				fin_q  <= fin_after;
				mode_q <= mode_after;
			end
		end
	end

	// output sequencer: first result, then flush bytes, then end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			fcnt_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (accept) begin
			if (r1_valid) begin
				out_valid_q       <= 1'b1;
				out_q.kind        <= r1_kind;
				out_q.out_byte    <= r1_byte;
				out_q.last_of_run <= !pending;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			fcnt_q <= cnt_after;
			if (!pending) begin
				state_q <= S_RUN;
			end else if (cnt_after != '0) begin
				state_q <= S_FLUSH;
			end else begin
				state_q <= S_END;
			end
		end else begin
			case (state_q)
				S_RUN: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_FLUSH: begin
					if (slot_free) begin
						out_valid_q       <= 1'b1;
						out_q.kind        <= KIND_BYTE;
						out_q.out_byte    <= stat.head;
						out_q.last_of_run <= 1'b0;
						fcnt_q            <= fcnt_q - CNT_W'(1);
						if (fcnt_q == CNT_W'(1)) begin
							state_q <= S_END;
						end
					end
				end
				S_END: begin
					if (slot_free) begin
						out_valid_q       <= 1'b1;
						out_q.kind        <= KIND_END;
						out_q.out_byte    <= 8'h00;
						out_q.last_of_run <= 1'b1;
						state_q           <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`HTMT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CNT_W'(MARKER_MAX), "window count too large")
	`HTMT_ASSERT_IMP(a_fin_empty, fin_q, cnt_q == '0, "window not empty after tail match")
	`HTMT_ASSERT_NXT(a_flush_end, (state_q == S_FLUSH) && (fcnt_q == CNT_W'(1)) && slot_free, state_q == S_END, "flush did not hand over to end")
	`HTMT_ASSERT_IMP(a_end_last, out_valid_q && (out_q.kind == KIND_END), out_q.last_of_run, "end result not last of run")
	`HTMT_ASSERT_IMP(a_nonbyte_zero, out_valid_q && (out_q.kind != KIND_BYTE), out_q.out_byte == 8'h00, "byte field set on a marker result")

endmodule

/* design/htmt_cell.sv */
// one byte cell of the marker window: holds a byte, loads or takes its neighbor
// depends on htmt_pkg
module htmt_cell import htmt_pkg::*; (
	input  logic        clk,
	input  chain_ctrl_t ctrl,
	input  logic        sel,
	input  logic        live,
	input  logic [7:0]  din,
	input  logic [7:0]  right,
	input  logic [7:0]  pat_byte,
	output logic [7:0]  q,
	output logic        hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			byte_q <= din;
		end else if (ctrl.shift) begin
			byte_q <= right;
		end
	end

	assign q   = byte_q;
	// cells past the fill level never block a match
	assign hit = !live || (byte_q == pat_byte);

endmodule

/* design/htmt_chain.sv */
// marker window built as a row of byte cells, oldest byte in cell 0
// depends on htmt_pkg and htmt_cell
module htmt_chain import htmt_pkg::*; #(
	parameter int MARKER_MAX = MARKER_MAX_DEF,
	localparam int CNT_W = $clog2(MARKER_MAX + 1)
) (
	input  logic             clk,
	input  chain_ctrl_t      ctrl,
	input  logic [CNT_W-1:0] wpos,
	input  logic [CNT_W-1:0] live_cnt,
	input  logic [7:0]       din,
	input  logic [PAT_W-1:0] pat,
	output chain_stat_t      stat
);

	logic [7:0]            cell_q [MARKER_MAX];
	logic [MARKER_MAX-1:0] hits;

	for (genvar i = 0; i < MARKER_MAX; i++) begin : g_cell
		logic [7:0] right;

		if (i == MARKER_MAX - 1) begin : g_end
			assign right = 8'h00;
		end else begin : g_mid
			assign right = cell_q[i+1];
		end

		htmt_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.sel      (wpos == CNT_W'(i)),
			.live     (CNT_W'(i) < live_cnt),
			.din      (din),
			.right    (right),
			.pat_byte (pat[8*i +: 8]),
			.q        (cell_q[i]),
			.hit      (hits[i])
		);
	end

	assign stat.hit_all = &hits;
	assign stat.head    = cell_q[0];

endmodule
